/* design/ntt_pm_pkg.sv */
// ----------------------------------------------------------------------------
// ntt_pm_pkg: shared definitions for the polynomial multiplier
// Field widths, the prime modulus, command and status codes, the sequencer
// states, the token that moves along the multiplier chain, and a modular add.
// ----------------------------------------------------------------------------
package ntt_pm_pkg;

	localparam int COEF_W = 30;
	localparam int IDX_W  = 11;
	localparam int OP_W   = 2;
	localparam int ST_W   = 2;

	localparam logic [COEF_W-1:0] PRIME = 30'd998244353;

	localparam int DEF_MAX_TERMS      = 1024;
	localparam int DEF_TRANSFORM_SIZE = 2048;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD_A   = 2'd0,
		OP_LOAD_B   = 2'd1,
		OP_MULTIPLY = 2'd2,
		OP_READ     = 2'd3
	} opcode_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_RUN,
		SEQ_DRAIN,
		SEQ_FIN
	} seq_state_t;

	// One partial product in flight: multiplicand a, the multiplier bits
	// still to be consumed in b (MSB first), and the running residue.
	typedef struct packed {
		logic              valid;
		logic              last;
		logic [COEF_W-1:0] acc;
		logic [COEF_W-1:0] a;
		logic [COEF_W-1:0] b;
	} tok_t;

	// Sum of two residues, reduced once.
	function automatic logic [COEF_W-1:0] mod_add(input logic [COEF_W-1:0] x,
			input logic [COEF_W-1:0] y);
		logic [COEF_W:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, PRIME}) begin
			s = s - {1'b0, PRIME};
		end
		return s[COEF_W-1:0];
	endfunction

endpackage

/* design/ntt_pm_if.sv */
// ----------------------------------------------------------------------------
// ntt_pm_in_if / ntt_pm_out_if: command and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ntt_pm_in_if;
	import ntt_pm_pkg::*;
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     opcode;
	logic [COEF_W-1:0]   coefficient;
	logic [IDX_W-1:0]    read_index;

	modport source(output valid, output opcode, output coefficient, output read_index,
		input ready);
	modport sink(input valid, input opcode, input coefficient, input read_index,
		output ready);
endinterface

interface ntt_pm_out_if;
	import ntt_pm_pkg::*;
	logic                valid;
	logic                ready;
	logic [ST_W-1:0]     status;
	logic [COEF_W-1:0]   product_coefficient;
	logic [IDX_W-1:0]    product_length;

	modport source(output valid, output status, output product_coefficient,
		output product_length, input ready);
	modport sink(input valid, input status, input product_coefficient,
		input product_length, output ready);
endinterface

/* design/ntt_polynomial_multiplier_core.sv */
// ----------------------------------------------------------------------------
// ntt_polynomial_multiplier_core: polynomial product modulo 998244353
// Operand stores, a product store, a sequencer and a chain of multiply cells.
// ----------------------------------------------------------------------------
// Usage: commands arrive on in_ch, one result beat per command leaves on
// out_ch. Load A / load B append a coefficient (reduced once) to an operand
// store; a full store drops it with status FULL. Read returns one product
// coefficient, or status RANGE and zero past the product length. Multiply
// replaces the product with the convolution of A and B and empties both.
// Loads and reads are taken one per cycle while idle and the result stage is
// free; each result beat passes the result stage, then the output register.
// A multiply with operand lengths la and lb issues la*lb partial products, one
// per cycle, through a 30-cell chain that retires one multiplier bit per
// cell; its result beat follows the last product written, and no command
// is taken until the sequencer is back in idle.
// An empty operand makes the multiply skip the chain and finish with length 0.
// Reset empties all counts; store contents are undefined until written.
// A stalled receiver holds the result register; one more result waits in an
// internal stage, after which in_ch.ready drops until out_ch drains.
// ----------------------------------------------------------------------------
module ntt_polynomial_multiplier_core #(
	parameter int MAX_TERMS      = ntt_pm_pkg::DEF_MAX_TERMS,
	parameter int TRANSFORM_SIZE = ntt_pm_pkg::DEF_TRANSFORM_SIZE
) (
	input  logic          clk,
	input  logic          arst_n,
	ntt_pm_in_if.sink     in_ch,
	ntt_pm_out_if.source  out_ch
);
	import ntt_pm_pkg::*;

	localparam int CW    = $clog2(MAX_TERMS + 1);
	localparam int AW    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int LW    = $clog2(TRANSFORM_SIZE + 1);
	localparam int PW    = $clog2(TRANSFORM_SIZE);
	localparam int SW    = (CW + 1 > LW) ? CW + 1 : LW;
	localparam int NCELL = COEF_W;

	// Storage.
	logic [COEF_W-1:0] amem [MAX_TERMS];
	logic [COEF_W-1:0] bmem [MAX_TERMS];
	logic [COEF_W-1:0] pmem [TRANSFORM_SIZE];

	seq_state_t        state_q, state_next;
	logic [CW-1:0]     first_count_q, second_count_q;
	logic [CW-1:0]     la_q, lb_q, i_q;
	logic [LW-1:0]     prod_count_q, k_q, wk_q;
	logic [COEF_W-1:0] rd_a_q, rd_b_q, rd_p_q, run_q;
	logic              fresh_q;
	logic              iss_v_s1, iss_last_s1;

	logic              s1_v_q, s1_rdok_q;
	status_t           s1_status_q;
	logic [IDX_W-1:0]  s1_len_q;
	logic              out_v_q;
	status_t           out_status_q;
	logic [COEF_W-1:0] out_coef_q;
	logic [IDX_W-1:0]  out_len_q;

	opcode_t           in_op;
	logic              accept, adv, s1_free;
	logic [COEF_W-1:0] coef_red;
	logic              a_full, b_full, mul_empty, read_ok;
	logic [SW-1:0]     len_full, len_clip, hi_w, kn_w, lo_next, jb_w;
	logic              last_issue, k_last, done_exit;
	logic [AW-1:0]     ia, ib;
	tok_t              tok [NCELL+1];
	tok_t              tex;
	logic [COEF_W-1:0] sum;

	// Command decode and handshake.
	assign in_op    = opcode_t'(in_ch.opcode);
	assign adv      = !out_v_q || out_ch.ready;
	assign s1_free  = !s1_v_q || adv;
	assign in_ch.ready = (state_q == SEQ_IDLE) && s1_free;
	assign accept   = in_ch.valid && in_ch.ready;
	assign coef_red = (in_ch.coefficient >= PRIME) ? in_ch.coefficient - PRIME
		: in_ch.coefficient;
	assign a_full   = first_count_q == CW'(MAX_TERMS);
	assign b_full   = second_count_q == CW'(MAX_TERMS);
	assign read_ok  = (32'(in_ch.read_index) < 32'(prod_count_q))
		&& (32'(in_ch.read_index) < 32'(TRANSFORM_SIZE));

	// Product length of a multiply.
	assign mul_empty = (first_count_q == '0) || (second_count_q == '0);
	assign len_full  = SW'(first_count_q) + SW'(second_count_q) - SW'(1);
	assign len_clip  = (len_full > SW'(TRANSFORM_SIZE)) ? SW'(TRANSFORM_SIZE) : len_full;

	// Term enumeration: for output k, i runs from max(0, k-lb+1) to min(k, la-1).
	assign hi_w       = (SW'(k_q) < SW'(la_q)) ? SW'(k_q) : SW'(la_q) - SW'(1);
	assign last_issue = SW'(i_q) == hi_w;
	assign k_last     = SW'(k_q) == SW'(prod_count_q) - SW'(1);
	assign kn_w       = SW'(k_q) + SW'(1);
	assign lo_next    = (kn_w >= SW'(lb_q)) ? kn_w - SW'(lb_q) + SW'(1) : '0;
	assign jb_w       = SW'(k_q) - SW'(i_q);
	assign ia         = i_q[AW-1:0];
	assign ib         = jb_w[AW-1:0];

	// Operand stores: append on load, read one term pair per cycle.
	always_ff @(posedge clk) begin
		if (accept && in_op == OP_LOAD_A && !a_full) begin
			amem[first_count_q[AW-1:0]] <= coef_red;
		end
		if (accept && in_op == OP_LOAD_B && !b_full) begin
			bmem[second_count_q[AW-1:0]] <= coef_red;
		end
		rd_a_q <= amem[ia];
		rd_b_q <= bmem[ib];
	end

	// Counts and the term sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_count_q  <= '0;
			second_count_q <= '0;
			prod_count_q   <= '0;
			la_q           <= '0;
			lb_q           <= '0;
			i_q            <= '0;
			k_q            <= '0;
			iss_v_s1       <= 1'b0;
			iss_last_s1    <= 1'b0;
		end else begin
			iss_v_s1    <= state_q == SEQ_RUN;
			iss_last_s1 <= last_issue;
			if (accept) begin
				case (in_op)
					OP_LOAD_A: begin
						if (!a_full) first_count_q <= first_count_q + CW'(1);
					end
					OP_LOAD_B: begin
						if (!b_full) second_count_q <= second_count_q + CW'(1);
					end
					OP_MULTIPLY: begin
						la_q           <= first_count_q;
						lb_q           <= second_count_q;
						first_count_q  <= '0;
						second_count_q <= '0;
						i_q            <= '0;
						k_q            <= '0;
						prod_count_q   <= mul_empty ? '0 : LW'(len_clip);
					end
					default: begin
					end
				endcase
			end else if (state_q == SEQ_RUN) begin
				if (last_issue) begin
					k_q <= k_q + LW'(1);
					i_q <= CW'(lo_next);
				end else begin
					i_q <= i_q + CW'(1);
				end
			end
		end
	end

	// Multiplier chain: one cell per multiplier bit.
	assign tok[0] = '{valid: iss_v_s1, last: iss_last_s1, acc: '0, a: rd_a_q, b: rd_b_q};

	for (genvar c = 0; c < NCELL; c++) begin : g_cell
		ntt_pm_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.din   (tok[c]),
			.dout  (tok[c+1])
		);
	end

	// Accumulate partial products of one output and write it to the store.
	assign tex       = tok[NCELL];
	assign sum       = mod_add(fresh_q ? '0 : run_q, tex.acc);
	assign done_exit = tex.valid && tex.last && (wk_q == prod_count_q - LW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q <= 1'b1;
			wk_q    <= '0;
		end else if (accept && in_op == OP_MULTIPLY) begin
			wk_q <= '0;
		end else if (tex.valid) begin
			fresh_q <= tex.last;
			if (tex.last) begin
				wk_q <= wk_q + LW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tex.valid) begin
			if (tex.last) begin
				pmem[wk_q[PW-1:0]] <= sum;
			end
			run_q <= sum;
		end
		if (accept) begin
			rd_p_q <= pmem[PW'(in_ch.read_index)];
		end
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			SEQ_IDLE: begin
				if (accept && in_op == OP_MULTIPLY) begin
					state_next = mul_empty ? SEQ_FIN : SEQ_RUN;
				end
			end
			SEQ_RUN: begin
				if (last_issue && k_last) state_next = SEQ_DRAIN;
			end
			SEQ_DRAIN: begin
				if (done_exit) state_next = SEQ_FIN;
			end
			SEQ_FIN: begin
				if (s1_free) state_next = SEQ_IDLE;
			end
			default: state_next = SEQ_IDLE;
		endcase
	end

	// Result stage and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (accept && in_op != OP_MULTIPLY) begin
				s1_v_q <= 1'b1;
			end else if (state_q == SEQ_FIN && s1_free) begin
				s1_v_q <= 1'b1;
			end else if (adv) begin
				s1_v_q <= 1'b0;
			end
			if (adv) begin
				out_v_q <= s1_v_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_op != OP_MULTIPLY) begin
			s1_len_q <= IDX_W'(prod_count_q);
			case (in_op)
				OP_LOAD_A: begin
					s1_status_q <= a_full ? ST_FULL : ST_OK;
					s1_rdok_q   <= 1'b0;
				end
				OP_LOAD_B: begin
					s1_status_q <= b_full ? ST_FULL : ST_OK;
					s1_rdok_q   <= 1'b0;
				end
				default: begin
					s1_status_q <= read_ok ? ST_OK : ST_RANGE;
					s1_rdok_q   <= read_ok;
				end
			endcase
		end else if (state_q == SEQ_FIN && s1_free) begin
			s1_len_q    <= IDX_W'(prod_count_q);
			s1_status_q <= ST_OK;
			s1_rdok_q   <= 1'b0;
		end
		if (adv && s1_v_q) begin
			out_status_q <= s1_status_q;
			out_coef_q   <= s1_rdok_q ? rd_p_q : '0;
			out_len_q    <= s1_len_q;
		end
	end

	assign out_ch.valid               = out_v_q;
	assign out_ch.status              = out_status_q;
	assign out_ch.product_coefficient = out_coef_q;
	assign out_ch.product_length      = out_len_q;

	// Operand counts never pass the store depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(first_count_q) <= MAX_TERMS) && (32'(second_count_q) <= MAX_TERMS))
		else $error("operand count beyond store depth");

	// Partial products leave the chain only while a multiply is in progress.
	a_chain_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tex.valid |-> (state_q == SEQ_RUN || state_q == SEQ_DRAIN))
		else $error("chain output outside a multiply");

	// No command is taken while a multiply is in progress.
	a_busy_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEQ_RUN || state_q == SEQ_DRAIN) |-> !in_ch.ready)
		else $error("command accepted during multiply");

endmodule

/* design/ntt_pm_cell.sv */
// ----------------------------------------------------------------------------
// ntt_pm_cell: one step of the shift-and-add modular multiplier chain
// Consumes the top multiplier bit: acc = 2*acc + bit*a, both reduced mod p.
// ----------------------------------------------------------------------------
module ntt_pm_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  ntt_pm_pkg::tok_t din,
	output ntt_pm_pkg::tok_t dout
);
	import ntt_pm_pkg::*;

	logic              valid_q;
	logic              last_q;
	logic [COEF_W-1:0] acc_q;
	logic [COEF_W-1:0] a_q;
	logic [COEF_W-1:0] b_q;
	logic [COEF_W-1:0] acc_next;

	// Double, then add the multiplicand when the current bit is set.
	always_comb begin
		acc_next = mod_add(din.acc, din.acc);
		if (din.b[COEF_W-1]) begin
			acc_next = mod_add(acc_next, din.a);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		last_q <= din.last;
		acc_q  <= acc_next;
		a_q    <= din.a;
		b_q    <= {din.b[COEF_W-2:0], 1'b0};
	end

	assign dout = '{valid: valid_q, last: last_q, acc: acc_q, a: a_q, b: b_q};

endmodule

/* sim/tb_ntt_polynomial_multiplier_core.sv */
// ----------------------------------------------------------------------------
// tb_ntt_polynomial_multiplier_core: self-checking bench for the multiplier
// Loads operands, multiplies and reads products back, while a local model
// computes each expected result beat. Both channel sides idle at random.
// ----------------------------------------------------------------------------
module tb_ntt_polynomial_multiplier_core;
	timeunit 1ns;
	timeprecision 1ps;
	import ntt_pm_pkg::*;

	localparam int TERMS = DEF_MAX_TERMS;
	localparam int PROD_DEPTH = DEF_TRANSFORM_SIZE;
	localparam longint MODULUS = 998244353;

	typedef struct {
		status_t          status;
		logic [COEF_W-1:0] coef;
		logic [IDX_W-1:0]  length;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #4 clk = ~clk;

	ntt_pm_in_if  cmd_ch();
	ntt_pm_out_if res_ch();

	ntt_polynomial_multiplier_core dut (
		.clk(clk), .arst_n(arst_n), .in_ch(cmd_ch.sink), .out_ch(res_ch.source)
	);

	// Local copy of the block state.
	logic [COEF_W-1:0] poly_a[TERMS];
	logic [COEF_W-1:0] poly_b[TERMS];
	logic [COEF_W-1:0] product[PROD_DEPTH];
	int len_a, len_b, len_prod;
	result_t pending_results[$];
	int mismatches = 0;
	bit calm = 1'b0;

	// Compute the result of one command and update the local state.
	function automatic result_t apply_command(opcode_t op, logic [COEF_W-1:0] c,
			logic [IDX_W-1:0] idx);
		result_t r;
		logic [COEF_W-1:0] v;
		longint acc;
		r.status = ST_OK;
		r.coef = '0;
		v = (c >= PRIME) ? c - PRIME : c;
		case (op)
			OP_LOAD_A: begin
				if (len_a >= TERMS) r.status = ST_FULL;
				else begin poly_a[len_a] = v; len_a++; end
			end
			OP_LOAD_B: begin
				if (len_b >= TERMS) r.status = ST_FULL;
				else begin poly_b[len_b] = v; len_b++; end
			end
			OP_MULTIPLY: begin
				if (len_a == 0 || len_b == 0) len_prod = 0;
				else begin
					len_prod = len_a + len_b - 1;
					for (int k = 0; k < len_prod; k++) begin
						acc = 0;
						for (int i = 0; i < len_a; i++) begin
							if (k - i >= 0 && k - i < len_b)
								acc = (acc + longint'(poly_a[i]) * longint'(poly_b[k-i]))
									% MODULUS;
						end
						product[k] = acc[COEF_W-1:0];
					end
				end
				len_a = 0;
				len_b = 0;
			end
			default: begin
				if (idx < len_prod) r.coef = product[idx];
				else r.status = ST_RANGE;
			end
		endcase
		r.length = len_prod[IDX_W-1:0];
		return r;
	endfunction

	function automatic bit idle_now();
		return !calm && ($urandom_range(99) < 17);
	endfunction

	// Send one command beat and record its expected result.
	task automatic send_command(opcode_t op, logic [COEF_W-1:0] c, logic [IDX_W-1:0] idx);
		while (idle_now()) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.opcode <= op;
		cmd_ch.coefficient <= c;
		cmd_ch.read_index <= idx;
		do @(posedge clk); while (!cmd_ch.ready);
		pending_results.push_back(apply_command(op, c, idx));
	endtask

	function automatic logic [COEF_W-1:0] rand_coef();
		case ($urandom_range(3))
			0: return PRIME - 1;
			1: return COEF_W'($urandom_range(1023));
			default: return COEF_W'($urandom);
		endcase
	endfunction

	// Result sink with random stalls and in-order checking.
	always @(posedge clk) begin
		result_t e;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result beat");
				end else begin
					e = pending_results.pop_front();
					if (res_ch.status !== e.status || res_ch.product_coefficient !== e.coef ||
							res_ch.product_length !== e.length) begin
						mismatches++;
						if (mismatches <= 10)
							$display("exp st=%0d c=%0d len=%0d got st=%0d c=%0d len=%0d",
								e.status, e.coef, e.length, res_ch.status,
								res_ch.product_coefficient, res_ch.product_length);
					end
				end
			end
			res_ch.ready <= !idle_now();
		end
	end

	// Extremes, every command, and each corner.
	task automatic test_directed();
		send_command(OP_READ, '0, '0);
		send_command(OP_MULTIPLY, '0, '0);
		send_command(OP_LOAD_A, 30'h3FFFFFFF, 11'h7FF);
		send_command(OP_MULTIPLY, '0, '0);
		send_command(OP_LOAD_A, PRIME, '0);
		send_command(OP_LOAD_A, PRIME - 1, '0);
		send_command(OP_LOAD_B, 30'h3FFFFFFF, '0);
		send_command(OP_LOAD_B, PRIME - 1, '0);
		send_command(OP_LOAD_B, 30'd0, '0);
		send_command(OP_MULTIPLY, '0, '0);
		for (int i = 0; i < 5; i++) send_command(OP_READ, '0, i[IDX_W-1:0]);
		send_command(OP_READ, '0, 11'h7FF);
	endtask

	// Fill A to capacity and overflow it, with a single B term.
	task automatic test_full_store();
		for (int i = 0; i < TERMS + 2; i++) send_command(OP_LOAD_A, rand_coef(), '0);
		send_command(OP_LOAD_B, rand_coef(), '0);
		send_command(OP_MULTIPLY, '0, '0);
		send_command(OP_READ, '0, 11'd2046);
		send_command(OP_READ, '0, 11'd2047);
		send_command(OP_READ, '0, '0);
	endtask

	// Short random polynomials, multiplied and read back, plus noise.
	task automatic test_random();
		int la, lb;
		for (int n = 0; n < 27; n++) begin
			calm = (n >= 15 && n < 20);
			la = $urandom_range(6);
			lb = $urandom_range(6);
			for (int i = 0; i < la; i++)
				send_command(OP_LOAD_A, rand_coef(), IDX_W'($urandom));
			for (int i = 0; i < lb; i++)
				send_command(OP_LOAD_B, rand_coef(), IDX_W'($urandom));
			send_command(OP_MULTIPLY, rand_coef(), IDX_W'($urandom));
			for (int i = 0; i < 12; i++)
				send_command(OP_READ, rand_coef(),
					($urandom_range(7) == 0) ? IDX_W'($urandom)
						: IDX_W'($urandom_range(12)));
		end
		calm = 1'b0;
	endtask

	initial begin
		int guard;
		cmd_ch.valid = 1'b0;
		cmd_ch.opcode = OP_READ;
		cmd_ch.coefficient = '0;
		cmd_ch.read_index = '0;
		res_ch.ready = 1'b0;
		len_a = 0;
		len_b = 0;
		len_prod = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_store();
		test_random();
		cmd_ch.valid <= 1'b0;
		guard = 0;
		while (pending_results.size() != 0 && guard < 3000000) begin
			@(posedge clk);
			guard++;
		end
		repeat (50) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("ntt_polynomial_multiplier_core: match");
		else
			$display("ntt_polynomial_multiplier_core: mismatch");
		$finish;
	end

	initial begin
		#40ms;
		$display("ntt_polynomial_multiplier_core: mismatch");
		$finish;
	end
endmodule
